// File: design/b64e_pkg.sv
// shared types, constants and the sextet-to-ascii function for the base64 encoder
// no dependencies; imported by every module of the block

package b64e_pkg;

   // group phase codes
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   // ascii codes
   localparam logic [6:0] PAD_CHAR     = 7'h3D;
   localparam logic [6:0] CHAR_PLUS    = 7'h2B;
   localparam logic [6:0] CHAR_SLASH   = 7'h2F;
   localparam logic [6:0] UPPER_BASE   = 7'd65;  // 'A'
   localparam logic [6:0] LOWER_BASE   = 7'd71;  // 'a' minus 26
   localparam logic [6:0] DIGIT_OFFSET = 7'd4;   // '0' is 52 plus this, minus 8

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // characters one byte gives rise to
   typedef struct packed {
      logic [3:0][6:0] chars;
      logic [1:0]      last_idx;
      logic            fin;
   } b64e_job_type;

   // standard alphabet lookup
   function automatic logic [6:0] b64e_char(input logic [5:0] v);
      logic [6:0] v7;
      v7 = {1'b0, v};
      if (v < 6'd26)      return UPPER_BASE + v7;
      else if (v < 6'd52) return LOWER_BASE + v7;
      else if (v < 6'd62) return v7 - DIGIT_OFFSET;
      else if (v == 6'd62) return CHAR_PLUS;
      else                return CHAR_SLASH;
   endfunction

endpackage

// File: design/b64e_front.sv
// front end: accepts bytes, tracks the group phase and leftover bits,
// builds one job of up to four characters per byte; uses b64e_pkg

module b64e_front
   import b64e_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_data_byte,
   input  logic         req_end_of_message,
   input  logic         queue_full,
   output logic         push,
   output b64e_job_type push_job
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] left_ff, left_in;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   // classify the byte by phase and form its characters
   always_comb begin
      push_job.chars    = {4{PAD_CHAR}};
      push_job.last_idx = 2'd0;
      push_job.fin      = req_end_of_message;
      phase_in          = phase_ff;
      left_in           = left_ff;
      case (phase_ff)
         PHASE_SECOND: begin
            push_job.chars[0] = b64e_char({left_ff[1:0], req_data_byte[7:4]});
            push_job.chars[1] = b64e_char({req_data_byte[3:0], 2'b00});
            push_job.last_idx = req_end_of_message ? 2'd2 : 2'd0;
            phase_in          = PHASE_THIRD;
            left_in           = req_data_byte[3:0];
         end
         PHASE_THIRD: begin
            push_job.chars[0] = b64e_char({left_ff, req_data_byte[7:6]});
            push_job.chars[1] = b64e_char(req_data_byte[5:0]);
            push_job.last_idx = 2'd1;
            phase_in          = PHASE_FIRST;
            left_in           = 4'd0;
         end
         default: begin
            push_job.chars[0] = b64e_char(req_data_byte[7:2]);
            push_job.chars[1] = b64e_char({req_data_byte[1:0], 4'b0000});
            push_job.last_idx = req_end_of_message ? 2'd3 : 2'd0;
            phase_in          = PHASE_SECOND;
            left_in           = {2'b00, req_data_byte[1:0]};
         end
      endcase
      // message end closes the group
      if (req_end_of_message) begin
         phase_in = PHASE_FIRST;
         left_in  = 4'd0;
      end
   end

   // phase and leftover registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_FIRST;
         left_ff  <= 4'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

// File: design/b64e_queue.sv
// short job queue between front and back ends
// register based, depth from b64e_pkg; uses b64e_pkg

module b64e_queue
   import b64e_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  b64e_job_type push_job,
   output logic         full,
   input  logic         pop,
   output b64e_job_type pop_job,
   output logic         empty
);

   b64e_job_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wptr_ff, rptr_ff;
   logic [QCNT_W-1:0]     count_ff;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = mem_ff[rptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_job;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         end
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// File: design/b64e_back.sv
// back end: takes jobs from the queue and sends their characters one per
// cycle while rsp_ready is high, marking the final one; uses b64e_pkg

module b64e_back
   import b64e_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         empty,
   input  b64e_job_type pop_job,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [6:0]   rsp_out_char,
   output logic         rsp_final_char
);

   b64e_job_type cur_job_ff;
   logic         cur_valid_ff;
   logic [1:0]   idx_ff;
   logic         at_last;
   logic         word_out;

   assign at_last        = (idx_ff == cur_job_ff.last_idx);
   assign word_out       = rsp_valid && rsp_ready;
   assign rsp_valid      = cur_valid_ff;
   assign rsp_out_char   = cur_job_ff.chars[idx_ff];
   assign rsp_final_char = cur_job_ff.fin && at_last;

   // load a new job when idle or when the last word of the current one leaves
   assign pop = !empty && (!cur_valid_ff || (word_out && at_last));

   always_ff @(posedge clock) begin
      if (pop) cur_job_ff <= pop_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (pop) begin
         cur_valid_ff <= 1'b1;
         idx_ff       <= 2'd0;
      end else if (word_out) begin
         if (at_last) begin
            cur_valid_ff <= 1'b0;
            idx_ff       <= 2'd0;
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // index never runs past the job
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> idx_ff <= cur_job_ff.last_idx)
      else $error("character index beyond job length");

   // stalled word keeps its position
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(idx_ff) && cur_valid_ff))
      else $error("character index moved under stall");

   // after the final character a new message starts at its first character
   a_final_restart: assert property (@(posedge clock) disable iff (reset)
      (word_out && rsp_final_char) |=> (idx_ff == 2'd0))
      else $error("new message does not start at first character");

   // a job is only loaded from a non-empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty job queue");

endmodule

// File: design/base64_stream_encoder_core.sv
// top level of the streaming base64 encoder: front end, job queue, back end
// depends on b64e_pkg, b64e_front, b64e_queue and b64e_back
//
// usage:
//   req channel: one raw byte per word (req_data_byte), with
//     req_end_of_message high on the last byte of a message.
//   rsp channel: one ascii character per word (rsp_out_char), from the
//     standard alphabet or '=' padding; rsp_final_char marks the last
//     character of a message, whose output is padded to a multiple of four.
//   each byte gives one or two characters, a message end up to four.
//   path: an accepted byte is written into the job queue and then loaded
//     into the back end's job register, from which its characters are
//     offered.
//   throughput: one character per cycle while rsp_ready is high, set by
//     the single output register of the back end; a byte gives 1 to 4
//     characters, on average four thirds; the front takes a byte every
//     cycle while the two-entry job queue has room.
//   stall: when rsp_ready is low the current character holds, the queue
//     fills and then req_ready drops.
//   reset: clears phase, leftover bits, queue and output; no output pending.

module base64_stream_encoder_core
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_out_char,
   output logic       rsp_final_char
);

   logic         push, pop, full, empty;
   b64e_job_type push_job, pop_job;

   // byte classification
   b64e_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .queue_full         (full),
      .push               (push),
      .push_job           (push_job)
   );

   // decoupling queue
   b64e_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (empty)
   );

   // character output
   b64e_back u_back (
      .clock          (clock),
      .reset          (reset),
      .empty          (empty),
      .pop_job        (pop_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_final_char (rsp_final_char)
   );

endmodule
